@@ hw/rtl/chunk_slice_sender_defines.svh @@
// Assertion macros shared by the chunk slice sender checker.
`ifndef CHUNK_SLICE_SENDER_DEFINES_SVH
`define CHUNK_SLICE_SENDER_DEFINES_SVH

// Same-cycle implication, held off while reset is low.
`define CSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is low.
`define CSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/css_pkg.sv @@
// Shared constants, codes and types of the chunk slice sender.
package css_pkg;

  localparam int unsigned SLICE_BYTES     = 1024;
  localparam int unsigned MAX_SLICES      = 32;
  localparam int unsigned SLICE_SHIFT     = $clog2(SLICE_BYTES);
  localparam int unsigned SLICE_IDX_W     = $clog2(MAX_SLICES);
  localparam int unsigned COUNT_W         = $clog2(MAX_SLICES + 1);
  localparam int unsigned MAX_CHUNK_BYTES = SLICE_BYTES * MAX_SLICES;

  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CHUNK_ID_W = 16;
  localparam int unsigned BITMAP_W   = 32;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned BYTES_W    = 11;
  localparam int unsigned OFFSET_W   = SLICE_IDX_W + SLICE_SHIFT;

  localparam logic [TIME_W-1:0] RESEND_RESET = TIME_W'(100);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_ACK   = 2'd2
  } func_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE        = 3'd0,
    KIND_SLICE       = 3'd1,
    KIND_START_OK    = 3'd2,
    KIND_START_REJ   = 3'd3,
    KIND_ACK_TAKEN   = 3'd4,
    KIND_ACK_IGNORED = 3'd5
  } result_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_ACK,
    ST_EMIT
  } css_state_e;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [SIZE_W-1:0]     chunk_size;
    logic [TIME_W-1:0]     now;
    logic [CHUNK_ID_W-1:0] ack_chunk_id;
    logic [COUNT_W-1:0]    ack_num_slices;
    logic [BITMAP_W-1:0]   ack_bitmap;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]      result_kind;
    logic [CHUNK_ID_W-1:0]  out_chunk_id;
    logic [SLICE_IDX_W-1:0] out_slice_id;
    logic [COUNT_W-1:0]     out_num_slices;
    logic [BYTES_W-1:0]     out_slice_bytes;
    logic [OFFSET_W-1:0]    out_data_offset;
    logic                   busy_res;
    logic [COUNT_W-1:0]     acked_count;
    logic                   chunk_done;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic         load;
    logic         start;
    logic         set_kind;
    result_kind_e kind;
    logic         scan_next;
    logic         scan_hit;
    logic         scan_done;
    logic         ack_step;
    logic         emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              busy;
    logic              size_ok;
    logic              ack_match;
    logic              hit;
    logic              last_step;
    logic              out_free;
  } status_t;

endpackage

@@ hw/rtl/css_if.sv @@
// Request and result channel interfaces of the chunk slice sender.
interface css_req_if;
  logic               valid;
  logic               ready;
  css_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface css_res_if;
  logic               valid;
  logic               ready;
  css_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/css_ctrl.sv @@
// Controller state machine: sequences dispatch, slice scan, ack merge and emit.
module css_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  css_pkg::status_t status_i,
  output css_pkg::cmd_t    cmd_o
);

  css_pkg::css_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= css_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      css_pkg::ST_IDLE: begin
        if (req_valid_i) state_d = css_pkg::ST_DISPATCH;
      end
      css_pkg::ST_DISPATCH: begin
        unique case (status_i.func)
          css_pkg::FUNC_TICK: begin
            state_d = status_i.busy ? css_pkg::ST_SCAN : css_pkg::ST_EMIT;
          end
          css_pkg::FUNC_ACK: begin
            state_d = status_i.ack_match ? css_pkg::ST_ACK : css_pkg::ST_EMIT;
          end
          default: state_d = css_pkg::ST_EMIT;
        endcase
      end
      css_pkg::ST_SCAN: begin
        if (status_i.hit || status_i.last_step) state_d = css_pkg::ST_EMIT;
      end
      css_pkg::ST_ACK: begin
        if (status_i.last_step) state_d = css_pkg::ST_EMIT;
      end
      css_pkg::ST_EMIT: begin
        if (status_i.out_free) state_d = css_pkg::ST_IDLE;
      end
      default: state_d = css_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o = 1'b0;
    cmd_o       = '0;
    cmd_o.kind  = css_pkg::KIND_NONE;
    unique case (state_q)
      css_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      css_pkg::ST_DISPATCH: begin
        unique case (status_i.func)
          css_pkg::FUNC_START: begin
            cmd_o.set_kind = 1'b1;
            if (status_i.busy || !status_i.size_ok) begin
              cmd_o.kind = css_pkg::KIND_START_REJ;
            end else begin
              cmd_o.kind  = css_pkg::KIND_START_OK;
              cmd_o.start = 1'b1;
            end
          end
          css_pkg::FUNC_ACK: begin
            cmd_o.set_kind = 1'b1;
            cmd_o.kind     = status_i.ack_match ? css_pkg::KIND_ACK_TAKEN
                                                : css_pkg::KIND_ACK_IGNORED;
          end
          default: ;
        endcase
      end
      css_pkg::ST_SCAN: begin
        if (status_i.hit) begin
          cmd_o.scan_hit = 1'b1;
        end else if (status_i.last_step) begin
          cmd_o.scan_done = 1'b1;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      css_pkg::ST_ACK: begin
        cmd_o.ack_step = 1'b1;
      end
      css_pkg::ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/css_dp.sv @@
// Datapath: chunk state, ack marks, per-slice send timers and result register.
module css_dp #(
  parameter logic [css_pkg::TIME_W-1:0] RESEND_RESET = css_pkg::RESEND_RESET
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [css_pkg::TIME_W-1:0]      cfg_data_i,
  input  css_pkg::in_item_t               req_item_i,
  input  css_pkg::cmd_t                   cmd_i,
  output css_pkg::status_t                status_o,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output css_pkg::out_item_t              res_item_o
);

  localparam int unsigned IDX_W   = css_pkg::SLICE_IDX_W;
  localparam int unsigned CNT_W   = css_pkg::COUNT_W;
  localparam int unsigned TIME_W  = css_pkg::TIME_W;
  localparam int unsigned SIZE_W  = css_pkg::SIZE_W;
  localparam int unsigned BYTES_W = css_pkg::BYTES_W;
  localparam int unsigned OFF_W   = css_pkg::OFFSET_W;
  localparam int unsigned ID_W    = css_pkg::CHUNK_ID_W;
  localparam int unsigned NSL     = css_pkg::MAX_SLICES;

  logic [TIME_W-1:0]  resend_q;
  css_pkg::in_item_t  item_q;

  logic               busy_q;
  logic [ID_W-1:0]    chunk_id_q;
  logic [SIZE_W-1:0]  chunk_bytes_q;
  logic [CNT_W-1:0]   slice_count_q;
  logic [IDX_W-1:0]   scan_start_q;
  logic [CNT_W-1:0]   acked_total_q;
  logic [NSL-1:0]     acked_marks_q;
  logic [TIME_W-1:0]  sent_time_q [NSL];

  logic [IDX_W-1:0]   id_q;
  logic [IDX_W-1:0]   step_q;

  css_pkg::result_kind_e kind_q;
  logic [ID_W-1:0]    cid_q;
  logic [IDX_W-1:0]   sid_q;
  logic [BYTES_W-1:0] sbytes_q;
  logic [OFF_W-1:0]   soff_q;
  logic               done_q;

  logic               res_valid_q;
  css_pkg::out_item_t res_item_q;

  logic [CNT_W-1:0]   count_last;
  logic               id_is_last;
  logic               step_last;
  logic [IDX_W-1:0]   id_next;
  logic [IDX_W-1:0]   scan_start_next;
  logic [TIME_W:0]    due;
  logic               hit;
  logic [OFF_W-1:0]   slice_off;
  logic [BYTES_W-1:0] slice_bytes;
  logic [SIZE_W:0]    size_round;
  logic [CNT_W-1:0]   new_count;
  logic               size_ok;
  logic               ack_match;
  logic               ack_new;
  logic [CNT_W-1:0]   total_inc;
  logic               chunk_complete;
  logic               out_free;

  assign count_last      = slice_count_q - CNT_W'(1);
  assign id_is_last      = ({1'b0, id_q} == count_last);
  assign step_last       = ({1'b0, step_q} == count_last);
  assign id_next         = id_is_last ? '0 : id_q + IDX_W'(1);
  assign scan_start_next = ({1'b0, scan_start_q} == count_last) ? '0
                                                                : scan_start_q + IDX_W'(1);

  // Resend deadline is formed one bit wider so it never wraps.
  assign due = {1'b0, sent_time_q[id_q]} + {1'b0, resend_q};
  assign hit = !acked_marks_q[id_q] && (due < {1'b0, item_q.now});

  assign slice_off   = {id_q, {css_pkg::SLICE_SHIFT{1'b0}}};
  assign slice_bytes = id_is_last ? BYTES_W'(chunk_bytes_q - SIZE_W'(slice_off))
                                  : BYTES_W'(css_pkg::SLICE_BYTES);

  assign size_round = {1'b0, item_q.chunk_size} + (SIZE_W + 1)'(css_pkg::SLICE_BYTES - 1);
  assign new_count  = CNT_W'(size_round >> css_pkg::SLICE_SHIFT);
  assign size_ok    = (item_q.chunk_size != '0) &&
                      ({1'b0, item_q.chunk_size} <= (SIZE_W + 1)'(css_pkg::MAX_CHUNK_BYTES));

  assign ack_match = busy_q && (item_q.ack_chunk_id == chunk_id_q) &&
                     (item_q.ack_num_slices == slice_count_q);

  assign ack_new        = item_q.ack_bitmap[id_q] && !acked_marks_q[id_q];
  assign total_inc      = acked_total_q + CNT_W'(1);
  assign chunk_complete = cmd_i.ack_step && ack_new && (total_inc == slice_count_q);

  assign out_free = !res_valid_q || res_ready_i;

  always_comb begin
    status_o.func      = item_q.func;
    status_o.busy      = busy_q;
    status_o.size_ok   = size_ok;
    status_o.ack_match = ack_match;
    status_o.hit       = hit;
    status_o.last_step = step_last;
    status_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resend_q <= RESEND_RESET;
    end else if (cfg_we_i) begin
      resend_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= req_item_i;
  end

  // Chunk state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      chunk_id_q    <= '0;
      chunk_bytes_q <= '0;
      slice_count_q <= '0;
      scan_start_q  <= '0;
      acked_total_q <= '0;
      acked_marks_q <= '0;
    end else begin
      if (cmd_i.start) begin
        busy_q        <= 1'b1;
        chunk_bytes_q <= item_q.chunk_size;
        slice_count_q <= new_count;
        scan_start_q  <= '0;
        acked_total_q <= '0;
        acked_marks_q <= '0;
      end
      if (cmd_i.scan_hit || cmd_i.scan_done) scan_start_q <= scan_start_next;
      if (cmd_i.ack_step && ack_new) begin
        acked_marks_q[id_q] <= 1'b1;
        acked_total_q       <= total_inc;
      end
      if (chunk_complete) begin
        busy_q     <= 1'b0;
        chunk_id_q <= chunk_id_q + ID_W'(1);
      end
    end
  end

  // Per-slice send timers: clear on start, stamp on send.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSL; i++) sent_time_q[i] <= '0;
    end else if (cmd_i.start) begin
      for (int i = 0; i < NSL; i++) sent_time_q[i] <= '0;
    end else if (cmd_i.scan_hit) begin
      sent_time_q[id_q] <= item_q.now;
    end
  end

  // Scan cursor and working result of the current request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q     <= '0;
      step_q   <= '0;
      kind_q   <= css_pkg::KIND_NONE;
      cid_q    <= '0;
      sid_q    <= '0;
      sbytes_q <= '0;
      soff_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        // Scan starts at the rotating index, ack merge at slice zero.
        id_q     <= (req_item_i.func == css_pkg::FUNC_TICK) ? scan_start_q : '0;
        step_q   <= '0;
        kind_q   <= css_pkg::KIND_NONE;
        cid_q    <= '0;
        sid_q    <= '0;
        sbytes_q <= '0;
        soff_q   <= '0;
        done_q   <= 1'b0;
      end
      if (cmd_i.set_kind) kind_q <= cmd_i.kind;
      if (cmd_i.scan_next || cmd_i.ack_step) begin
        id_q   <= id_next;
        step_q <= step_q + IDX_W'(1);
      end
      if (cmd_i.scan_hit) begin
        kind_q   <= css_pkg::KIND_SLICE;
        cid_q    <= chunk_id_q;
        sid_q    <= id_q;
        sbytes_q <= slice_bytes;
        soff_q   <= slice_off;
      end
      if (chunk_complete) done_q <= 1'b1;
    end
  end

  // Output register: the next request is taken while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_item_q.result_kind     <= kind_q;
      res_item_q.out_chunk_id    <= cid_q;
      res_item_q.out_slice_id    <= sid_q;
      res_item_q.out_num_slices  <= slice_count_q;
      res_item_q.out_slice_bytes <= sbytes_q;
      res_item_q.out_data_offset <= soff_q;
      res_item_q.busy_res        <= busy_q;
      res_item_q.acked_count     <= acked_total_q;
      res_item_q.chunk_done      <= done_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_item_o  = res_item_q;

endmodule

@@ hw/rtl/chunk_slice_sender.sv @@
// Top level of the chunk slice sender: controller plus datapath.
//
//   channel  | dir | handshake     | carries
//   ---------+-----+---------------+---------------------------------------
//   req_if   | in  | valid/ready   | func, chunk size, time, ack contents
//   res_if   | out | valid/ready   | one result per request
//   cfg      | in  | cfg_we_i      | resend interval, no read-back
//
// Start, rejected requests, idle ticks and ignored acks go through dispatch and emit only.
// A tick while sending scans from a rotating start, up to the slice count (32 max):
// one slice timer is checked per cycle against the time of the request.
// An ack that matches merges one ack bit per cycle, across the slice count.
// A new request is taken while the previous result waits in the output register.
// Reset is asynchronous, active low; it clears state, timers and ack marks.
module chunk_slice_sender #(
  parameter logic [css_pkg::TIME_W-1:0] RESEND_RESET = css_pkg::RESEND_RESET
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [css_pkg::TIME_W-1:0] cfg_data_i,
  css_req_if.sink                    req_if,
  css_res_if.source                  res_if
);

  css_pkg::cmd_t    cmd;
  css_pkg::status_t status;

  css_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_ready_o (req_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  css_dp #(
    .RESEND_RESET (RESEND_RESET)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .req_item_i  (req_if.payload),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_item_o  (res_if.payload)
  );

endmodule

@@ hw/rtl/css_checker.sv @@
// Port-level checker of the chunk slice sender and its bind.
`include "chunk_slice_sender_defines.svh"

module css_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               res_valid_i,
  input logic               res_ready_i,
  input css_pkg::out_item_t res_item_i
);

  `CSS_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, (res_valid_i && !res_ready_i), (res_valid_i && $stable(res_item_i)), "result dropped or changed while stalled")

  `CSS_ASSERT_IMPLY(a_no_slice_zero, clk_i, rst_ni, (res_valid_i && res_item_i.result_kind != css_pkg::KIND_SLICE), (res_item_i.out_chunk_id == '0 && res_item_i.out_slice_id == '0 && res_item_i.out_slice_bytes == '0 && res_item_i.out_data_offset == '0), "slice fields set on a non-slice result")

  `CSS_ASSERT_IMPLY(a_done_state, clk_i, rst_ni, (res_valid_i && res_item_i.chunk_done), (!res_item_i.busy_res && res_item_i.result_kind == css_pkg::KIND_ACK_TAKEN && res_item_i.acked_count == res_item_i.out_num_slices), "chunk done without a full ack")

  `CSS_ASSERT_IMPLY(a_slice_geom, clk_i, rst_ni, (res_valid_i && res_item_i.result_kind == css_pkg::KIND_SLICE), (res_item_i.busy_res && {1'b0, res_item_i.out_slice_id} < res_item_i.out_num_slices && res_item_i.out_data_offset == {res_item_i.out_slice_id, {css_pkg::SLICE_SHIFT{1'b0}}} && res_item_i.out_slice_bytes != '0 && res_item_i.out_slice_bytes <= css_pkg::BYTES_W'(css_pkg::SLICE_BYTES)), "slice geometry out of range")

endmodule

bind chunk_slice_sender css_checker u_css_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_if.valid),
  .res_ready_i (res_if.ready),
  .res_item_i  (res_if.payload)
);

@@ tb/chunk_slice_sender_tb.sv @@
// Self-checking testbench of the chunk slice sender: directed table, then random phases.
`timescale 1ns / 1ps

module chunk_slice_sender_tb;
  import css_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 222;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned MAX_GAP         = 6;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [TIME_W-1:0]   cfg_data_i = '0;

  css_req_if req_if ();
  css_res_if res_if ();

  chunk_slice_sender dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_if     (req_if),
    .res_if     (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Sender state as the predictor sees it.
  bit                    snd_busy = 1'b0;
  logic [CHUNK_ID_W-1:0] snd_chunk_id = '0;
  int unsigned           snd_bytes = 0;
  int unsigned           snd_slices = 0;
  int unsigned           snd_scan = 0;
  int unsigned           snd_acked_total = 0;
  bit [MAX_SLICES-1:0]   snd_acked = '0;
  logic [TIME_W-1:0]     snd_sent_at [MAX_SLICES];
  logic [TIME_W-1:0]     resend_ival = RESEND_RESET;

  out_item_t   pending_results [$];
  dir_row_t    dir_rows [$];
  bit          idle_on = 1'b1;
  logic [TIME_W-1:0] now_base = '0;
  int unsigned n_faults = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_slices_sent = 0;
  int unsigned n_chunks_done = 0;

  initial begin
    foreach (snd_sent_at[i]) snd_sent_at[i] = '0;
  end

  function automatic out_item_t next_sender_result(input in_item_t rq);
    out_item_t   r;
    int unsigned id;
    bit          found;
    logic [32:0] due;
    r = '0;
    found = 1'b0;
    case (rq.func)
      FUNC_START: begin
        if (snd_busy || rq.chunk_size == 0 || rq.chunk_size > MAX_CHUNK_BYTES) begin
          r.result_kind = KIND_START_REJ;
        end else begin
          snd_busy = 1'b1;
          snd_bytes = rq.chunk_size;
          snd_slices = (snd_bytes + SLICE_BYTES - 1) / SLICE_BYTES;
          snd_scan = 0;
          snd_acked_total = 0;
          snd_acked = '0;
          foreach (snd_sent_at[i]) snd_sent_at[i] = '0;
          r.result_kind = KIND_START_OK;
        end
      end
      FUNC_TICK: begin
        if (snd_busy && snd_slices != 0) begin
          for (int i = 0; i < snd_slices; i++) begin
            id = (snd_scan + i) % snd_slices;
            if (!found && !snd_acked[id]) begin
              // Compare in 33 bits so the sum never wraps.
              due = {1'b0, snd_sent_at[id]} + {1'b0, resend_ival};
              if (due < {1'b0, rq.now}) begin
                found = 1'b1;
                r.result_kind = KIND_SLICE;
                r.out_chunk_id = snd_chunk_id;
                r.out_slice_id = SLICE_IDX_W'(id);
                r.out_slice_bytes = (id == snd_slices - 1) ?
                    BYTES_W'(snd_bytes - id * SLICE_BYTES) : BYTES_W'(SLICE_BYTES);
                r.out_data_offset = OFFSET_W'(id * SLICE_BYTES);
                snd_sent_at[id] = rq.now;
              end
            end
          end
          snd_scan = (snd_scan + 1) % snd_slices;
        end
      end
      FUNC_ACK: begin
        if (!snd_busy || rq.ack_chunk_id != snd_chunk_id || rq.ack_num_slices != snd_slices) begin
          r.result_kind = KIND_ACK_IGNORED;
        end else begin
          r.result_kind = KIND_ACK_TAKEN;
          for (int i = 0; i < snd_slices; i++) begin
            if (!snd_acked[i] && rq.ack_bitmap[i]) begin
              snd_acked[i] = 1'b1;
              snd_acked_total++;
              if (snd_acked_total == snd_slices) begin
                snd_busy = 1'b0;
                snd_chunk_id = snd_chunk_id + 1'b1;
                r.chunk_done = 1'b1;
              end
            end
          end
        end
      end
      default: r.result_kind = KIND_NONE;
    endcase
    r.out_num_slices = COUNT_W'(snd_slices);
    r.busy_res = snd_busy;
    r.acked_count = COUNT_W'(snd_acked_total);
    return r;
  endfunction

  function automatic in_item_t mk_req(input logic [FUNC_W-1:0] func, input int unsigned size,
                                      input logic [TIME_W-1:0] now, input int unsigned id,
                                      input int unsigned n, input logic [BITMAP_W-1:0] bits);
    in_item_t rq;
    rq.func = func;
    rq.chunk_size = SIZE_W'(size);
    rq.now = now;
    rq.ack_chunk_id = CHUNK_ID_W'(id);
    rq.ack_num_slices = COUNT_W'(n);
    rq.ack_bitmap = bits;
    return rq;
  endfunction

  function automatic out_item_t mk_res(input result_kind_e kind, input int unsigned slices,
                                       input bit busy, input int unsigned acked);
    out_item_t r;
    r = '0;
    r.result_kind = kind;
    r.out_num_slices = COUNT_W'(slices);
    r.busy_res = busy;
    r.acked_count = COUNT_W'(acked);
    return r;
  endfunction

  function automatic logic [BITMAP_W-1:0] pick_bitmap();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return BITMAP_W'(1) << $urandom_range(0, snd_slices - 1);
      default: return $urandom & $urandom;
    endcase
  endfunction

  function automatic int unsigned pick_size();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, SLICE_BYTES);
      1: return $urandom_range(1, MAX_CHUNK_BYTES);
      2: return $urandom_range(1, MAX_SLICES) * SLICE_BYTES;
      3: return $urandom_range(1, MAX_SLICES - 1) * SLICE_BYTES + 1;
      4: return $urandom_range(1, 4 * SLICE_BYTES);
      default: return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_CHUNK_BYTES + 1, 65535);
    endcase
  endfunction

  // Mostly well-formed traffic against the live chunk, with some noise mixed in.
  function automatic in_item_t pick_request();
    in_item_t rq;
    int unsigned r;
    rq = mk_req(FUNC_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: rq.func = FUNC_UNUSED;
        1: begin
          rq.func = FUNC_START;
          rq.chunk_size = SIZE_W'(pick_size());
        end
        2: rq.func = FUNC_ACK;
        default: rq.func = FUNC_TICK;
      endcase
    end else if (!snd_busy) begin
      if (r < 14) begin
        rq.func = (r < 11) ? FUNC_TICK : FUNC_ACK;
      end else begin
        rq.func = FUNC_START;
        rq.chunk_size = SIZE_W'(pick_size());
      end
    end else if (r < 65) begin
      rq.func = FUNC_TICK;
      now_base += ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1000) : $urandom_range(0, 40);
      rq.now = now_base;
    end else begin
      rq.func = FUNC_ACK;
      rq.ack_chunk_id = snd_chunk_id;
      rq.ack_num_slices = COUNT_W'(snd_slices);
      rq.ack_bitmap = pick_bitmap();
    end
    return rq;
  endfunction

  function automatic string show_result(input out_item_t r);
    return $sformatf("kind=%0d cid=%0d sid=%0d n=%0d bytes=%0d off=%0d busy=%0d acked=%0d done=%0d",
                     r.result_kind, r.out_chunk_id, r.out_slice_id, r.out_num_slices,
                     r.out_slice_bytes, r.out_data_offset, r.busy_res, r.acked_count,
                     r.chunk_done);
  endfunction

  task automatic note_fault(input string msg);
    n_faults++;
    if (n_faults <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_req(input in_item_t rq, input bit typed, input out_item_t typed_res);
    out_item_t exp;
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.payload = rq;
    req_if.valid = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    exp = next_sender_result(rq);
    // Typed rows keep the predictor in step but are checked against the table.
    if (typed) exp = typed_res;
    pending_results.push_back(exp);
    n_requests++;
    if (exp.result_kind == KIND_SLICE) n_slices_sent++;
    if (exp.chunk_done) n_chunks_done++;
  endtask

  // Drop valid and wait for every result to come back.
  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_resend(input logic [TIME_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_data_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    resend_ival = v;
  endtask

  // Result side: stall a random number of cycles before each result.
  initial begin
    int unsigned stall;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp;
    out_item_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.payload;
      if (pending_results.size() == 0) begin
        note_fault($sformatf("unexpected result %s", show_result(got)));
      end else begin
        exp = pending_results.pop_front();
        n_results++;
        if (exp.result_kind !== got.result_kind || exp.out_chunk_id !== got.out_chunk_id ||
            exp.out_slice_id !== got.out_slice_id || exp.out_num_slices !== got.out_num_slices ||
            exp.out_slice_bytes !== got.out_slice_bytes ||
            exp.out_data_offset !== got.out_data_offset || exp.busy_res !== got.busy_res ||
            exp.acked_count !== got.acked_count || exp.chunk_done !== got.chunk_done) begin
          note_fault($sformatf("expected %s / got %s", show_result(exp), show_result(got)));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0] phase_ival [NUM_PHASES];
    req_if.valid = 1'b0;
    req_if.payload = '0;

    // Idle and reject cases, then a full 32-slice chunk, then 1- and 2-slice chunks.
    dir_rows.push_back('{mk_req(FUNC_TICK, 0, '1, 0, 0, 0), 1'b1,
                         mk_res(KIND_NONE, 0, 1'b0, 0)});
    dir_rows.push_back('{mk_req(FUNC_ACK, 0, 0, 0, 1, '1), 1'b1,
                         mk_res(KIND_ACK_IGNORED, 0, 1'b0, 0)});
    dir_rows.push_back('{mk_req(FUNC_UNUSED, 65535, '1, 65535, 63, '1), 1'b1,
                         mk_res(KIND_NONE, 0, 1'b0, 0)});
    dir_rows.push_back('{mk_req(FUNC_START, 0, 0, 0, 0, 0), 1'b1,
                         mk_res(KIND_START_REJ, 0, 1'b0, 0)});
    dir_rows.push_back('{mk_req(FUNC_START, 65535, 0, 0, 0, 0), 1'b1,
                         mk_res(KIND_START_REJ, 0, 1'b0, 0)});
    dir_rows.push_back('{mk_req(FUNC_START, MAX_CHUNK_BYTES + 1, 0, 0, 0, 0), 1'b1,
                         mk_res(KIND_START_REJ, 0, 1'b0, 0)});
    dir_rows.push_back('{mk_req(FUNC_START, MAX_CHUNK_BYTES, 0, 0, 0, 0), 1'b1,
                         mk_res(KIND_START_OK, 32, 1'b1, 0)});
    dir_rows.push_back('{mk_req(FUNC_START, 1, 0, 0, 0, 0), 1'b1,
                         mk_res(KIND_START_REJ, 32, 1'b1, 0)});
    dir_rows.push_back('{mk_req(FUNC_TICK, 0, 100, 0, 0, 0), 1'b1,
                         mk_res(KIND_NONE, 32, 1'b1, 0)});
    dir_rows.push_back('{mk_req(FUNC_TICK, 0, 101, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_TICK, 0, '1, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_ACK, 0, 0, 1, 32, '1), 1'b1,
                         mk_res(KIND_ACK_IGNORED, 32, 1'b1, 0)});
    dir_rows.push_back('{mk_req(FUNC_ACK, 0, 0, 0, 31, '1), 1'b1,
                         mk_res(KIND_ACK_IGNORED, 32, 1'b1, 0)});
    dir_rows.push_back('{mk_req(FUNC_ACK, 0, 0, 0, 32, 32'h7FFF_FFFF), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_TICK, 0, '1, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_ACK, 0, 0, 0, 32, '1), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_START, 1, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_TICK, 0, '1, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_ACK, 0, 0, 1, 1, 32'hFFFF_FFFE), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_ACK, 0, 0, 1, 1, 32'h1), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_START, SLICE_BYTES + 1, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_ACK, 0, 0, 2, 2, 32'h2), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_TICK, 0, 1000, 0, 0, 0), 1'b0, '0});
    dir_rows.push_back('{mk_req(FUNC_ACK, 0, 0, 2, 2, 32'h3), 1'b0, '0});

    phase_ival[0] = '0;
    phase_ival[1] = '1;
    phase_ival[2] = 32'd1;
    phase_ival[3] = $urandom_range(2, 300);
    phase_ival[4] = RESEND_RESET;
    phase_ival[5] = $urandom;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_resend(phase_ival[ph]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Alternate stretches with and without bubbles on both sides.
        if (k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_req(pick_request(), 1'b0, '0);
      end
    end

    drain_results();
    $display("run covered %0d requests in %0d resend settings, %0d results checked",
             n_requests, NUM_PHASES + 1, n_results);
    $display("slices sent %0d, chunks completed %0d, mismatches %0d",
             n_slices_sent, n_chunks_done, n_faults);
    if (n_faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
